### src/lmrp_pkg.sv
// Shared constants, types and helper functions of the loopback message ring pair.
package lmrp_pkg;

    localparam int RING_SLOTS = 4;
    localparam int MSG_WORDS  = 64;

    localparam int DATA_W     = 64;
    localparam int BYTES_W    = 4;
    localparam int WORD_BYTES = 8;
    localparam int SH_W       = 3;

    localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int WORD_W     = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;
    localparam int ADDR_W     = 1 + SLOT_W + WORD_W;
    localparam int SLOT_BYTES = MSG_WORDS * WORD_BYTES;
    localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
    localparam int CUR_W      = $clog2(MSG_WORDS + 1);
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_GET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_SPILL,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < WORD_BYTES; i++) begin
            m[8*i +: 8] = (n > BYTES_W'(i)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

### src/lmrp_store.sv
// Message word memory: one write port, one read port with registered read data.
module lmrp_store (
    input  logic                                aclk,
    input  lmrp_pkg::mem_req_t                  mem_req,
    output logic [lmrp_pkg::DATA_W-1:0]         mem_rdata
);

    logic [lmrp_pkg::DATA_W-1:0] mem [2**lmrp_pkg::ADDR_W];
    logic [lmrp_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rdata_reg <= mem[mem_req.rd_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

### src/lmrp_ctrl.sv
// Ring bookkeeping, send merge sequencer and get streaming control.
module lmrp_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                s_side,
    input  logic [lmrp_pkg::DATA_W-1:0]         s_word_data,
    input  logic [lmrp_pkg::BYTES_W-1:0]        s_word_bytes,
    input  logic                                s_end_of_message,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [lmrp_pkg::DATA_W-1:0]         m_out_word,
    output logic [lmrp_pkg::BYTES_W-1:0]        m_out_bytes,
    output logic                                m_out_last,
    output lmrp_pkg::mem_req_t                  mem_req,
    input  logic [lmrp_pkg::DATA_W-1:0]         mem_rdata
);

    lmrp_pkg::state_t state_reg, state_next;

    logic [lmrp_pkg::SLOT_W-1:0] write_slot_reg [2];
    logic [lmrp_pkg::SLOT_W-1:0] read_slot_reg  [2];
    logic [lmrp_pkg::CNT_W-1:0]  held_reg       [2];
    logic [lmrp_pkg::CUR_W-1:0]  cursor_reg     [2];
    logic [lmrp_pkg::LEN_W-1:0]  slot_len_reg   [2][lmrp_pkg::RING_SLOTS];

    logic                          ring_reg;
    logic [lmrp_pkg::SLOT_W-1:0]   slot_reg;
    logic [lmrp_pkg::WORD_W-1:0]   word_reg;
    logic [lmrp_pkg::SH_W-1:0]     sh_reg;
    logic [lmrp_pkg::DATA_W-1:0]   data_reg;
    logic                          spill_reg;
    logic                          found_reg;
    logic [lmrp_pkg::LEN_W-1:0]    rem_reg;

    logic                          acc;
    logic                          acc_send;
    logic                          acc_get;
    logic                          out_acc;
    logic                          ring_tx;
    logic                          start;
    logic [lmrp_pkg::SLOT_W-1:0]   cur_slot;
    logic [lmrp_pkg::LEN_W-1:0]    len_cur;
    logic [lmrp_pkg::LEN_W-1:0]    room;
    logic [lmrp_pkg::BYTES_W-1:0]  nb_in;
    logic [lmrp_pkg::BYTES_W-1:0]  nb_eff;
    logic [lmrp_pkg::WORD_W-1:0]   word_w;
    logic [lmrp_pkg::SH_W-1:0]     sh_w;
    logic                          drop;
    logic [lmrp_pkg::CNT_W-1:0]    held_mid;
    logic                          has_msg;
    logic [lmrp_pkg::SLOT_W-1:0]   get_slot;
    logic [lmrp_pkg::LEN_W-1:0]    get_len;
    logic [lmrp_pkg::BYTES_W-1:0]  out_nb;
    logic                          out_last;
    logic [6:0]                    spill_shift;

    assign s_ready  = (state_reg == lmrp_pkg::ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign acc_send = acc && (s_mode == lmrp_pkg::MODE_SEND);
    assign acc_get  = acc && (s_mode == lmrp_pkg::MODE_GET);
    assign m_valid  = (state_reg == lmrp_pkg::ST_STREAM);
    assign out_acc  = m_valid && m_ready;

    assign ring_tx  = ~s_side;
    assign start    = (cursor_reg[ring_tx] == '0);
    assign cur_slot = write_slot_reg[ring_tx];
    assign len_cur  = start ? '0 : slot_len_reg[ring_tx][cur_slot];
    assign room     = lmrp_pkg::LEN_W'(lmrp_pkg::SLOT_BYTES) - len_cur;
    assign nb_in    = (s_word_bytes > lmrp_pkg::BYTES_W'(lmrp_pkg::WORD_BYTES))
                    ? lmrp_pkg::BYTES_W'(lmrp_pkg::WORD_BYTES) : s_word_bytes;
    assign nb_eff   = (lmrp_pkg::LEN_W'(nb_in) > room)
                    ? lmrp_pkg::BYTES_W'(room) : nb_in;
    assign word_w   = lmrp_pkg::WORD_W'(len_cur >> 3);
    assign sh_w     = len_cur[lmrp_pkg::SH_W-1:0];
    assign drop     = start && (held_reg[ring_tx] >= lmrp_pkg::CNT_W'(lmrp_pkg::RING_SLOTS));
    assign held_mid = drop ? lmrp_pkg::CNT_W'(lmrp_pkg::RING_SLOTS - 1) : held_reg[ring_tx];

    assign has_msg  = (held_reg[s_side] != '0);
    assign get_slot = read_slot_reg[s_side];
    assign get_len  = slot_len_reg[s_side][get_slot];

    assign out_nb   = (rem_reg > lmrp_pkg::LEN_W'(lmrp_pkg::WORD_BYTES))
                    ? lmrp_pkg::BYTES_W'(lmrp_pkg::WORD_BYTES) : lmrp_pkg::BYTES_W'(rem_reg);
    assign out_last = (rem_reg <= lmrp_pkg::LEN_W'(lmrp_pkg::WORD_BYTES));

    assign m_found     = found_reg;
    assign m_out_bytes = out_nb;
    assign m_out_last  = out_last;
    assign m_out_word  = found_reg ? (mem_rdata & lmrp_pkg::byte_mask(out_nb)) : '0;

    assign spill_shift = 7'(lmrp_pkg::DATA_W) - {1'b0, sh_reg, 3'b000};

    always_comb begin
        state_next      = state_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = {ring_reg, slot_reg, word_reg};
        mem_req.wr_data = (mem_rdata & lmrp_pkg::byte_mask(lmrp_pkg::BYTES_W'(sh_reg)))
                        | (data_reg << {sh_reg, 3'b000});
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = {ring_reg, slot_reg, word_reg + lmrp_pkg::WORD_W'(1)};
        case (state_reg)
            lmrp_pkg::ST_IDLE: begin
                if (acc_send && nb_eff != '0) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = {ring_tx, cur_slot, word_w};
                    state_next      = lmrp_pkg::ST_MERGE;
                end else if (acc_get) begin
                    mem_req.rd_en   = has_msg;
                    mem_req.rd_addr = {s_side, get_slot, lmrp_pkg::WORD_W'(0)};
                    state_next      = lmrp_pkg::ST_STREAM;
                end
            end
            lmrp_pkg::ST_MERGE: begin
                mem_req.wr_en = 1'b1;
                state_next    = spill_reg ? lmrp_pkg::ST_SPILL : lmrp_pkg::ST_IDLE;
            end
            lmrp_pkg::ST_SPILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {ring_reg, slot_reg, word_reg + lmrp_pkg::WORD_W'(1)};
                mem_req.wr_data = data_reg >> spill_shift;
                state_next      = lmrp_pkg::ST_IDLE;
            end
            lmrp_pkg::ST_STREAM: begin
                if (out_acc) begin
                    if (out_last) begin
                        state_next = lmrp_pkg::ST_IDLE;
                    end else begin
                        mem_req.rd_en = 1'b1;
                    end
                end
            end
            default: begin
                state_next = lmrp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmrp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 2; r++) begin
                write_slot_reg[r] <= '0;
                read_slot_reg[r]  <= '0;
                held_reg[r]       <= '0;
                cursor_reg[r]     <= '0;
            end
        end else if (acc_send) begin
            if (drop) begin
                read_slot_reg[ring_tx] <= lmrp_pkg::next_slot(read_slot_reg[ring_tx]);
            end
            if (s_end_of_message) begin
                cursor_reg[ring_tx]     <= '0;
                write_slot_reg[ring_tx] <= lmrp_pkg::next_slot(cur_slot);
                held_reg[ring_tx]       <=
                    (held_mid < lmrp_pkg::CNT_W'(lmrp_pkg::RING_SLOTS))
                    ? held_mid + lmrp_pkg::CNT_W'(1) : held_mid;
            end else begin
                held_reg[ring_tx] <= held_mid;
                if (cursor_reg[ring_tx] < lmrp_pkg::CUR_W'(lmrp_pkg::MSG_WORDS)) begin
                    cursor_reg[ring_tx] <= cursor_reg[ring_tx] + lmrp_pkg::CUR_W'(1);
                end
            end
        end else if (acc_get && has_msg) begin
            read_slot_reg[s_side] <= lmrp_pkg::next_slot(get_slot);
            held_reg[s_side]      <= held_reg[s_side] - lmrp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_send) begin
            slot_len_reg[ring_tx][cur_slot] <= len_cur + lmrp_pkg::LEN_W'(nb_eff);
            ring_reg  <= ring_tx;
            slot_reg  <= cur_slot;
            word_reg  <= word_w;
            sh_reg    <= sh_w;
            data_reg  <= s_word_data & lmrp_pkg::byte_mask(nb_eff);
            spill_reg <= ((4'(sh_w) + nb_eff) > 4'(lmrp_pkg::WORD_BYTES))
                      && (32'(word_w) + 1 < lmrp_pkg::MSG_WORDS);
        end else if (acc_get) begin
            ring_reg  <= s_side;
            slot_reg  <= get_slot;
            word_reg  <= '0;
            found_reg <= has_msg;
            rem_reg   <= has_msg ? get_len : '0;
        end else if (out_acc && !out_last) begin
            word_reg <= word_reg + lmrp_pkg::WORD_W'(1);
            rem_reg  <= rem_reg - lmrp_pkg::LEN_W'(lmrp_pkg::WORD_BYTES);
        end
    end

`ifndef SYNTH
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg[0] <= lmrp_pkg::CNT_W'(lmrp_pkg::RING_SLOTS)
        && held_reg[1] <= lmrp_pkg::CNT_W'(lmrp_pkg::RING_SLOTS))
        else $error("held count above ring capacity");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_merge_after_send: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == lmrp_pkg::ST_MERGE) |-> $past(acc_send))
        else $error("merge without a send transfer");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && out_last) |=> s_ready)
        else $error("block busy after final result transfer");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !found_reg) |-> (out_last && out_nb == '0))
        else $error("empty result not a single last word");
`endif

endmodule

### src/loopback_message_ring_pair.sv
// Top level of the loopback message ring pair.
// Two rings of message slots share one 64-bit word memory with one write and one
// registered read port. The block works on one item at a time. A send word that stores
// no bytes makes no memory access; one that fits the current memory word is read,
// merged and written back, and one whose bytes straddle into the next word also writes
// the remaining bytes to that next word. A get shows its first result in the cycle after
// the transfer and then one word per cycle while the result side is ready; an empty
// ring gives one result. The next item is taken in the cycle after the last result
// transfer or the last memory write. There is no clearing pass after reset.
module loopback_message_ring_pair (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                s_side,
    input  logic [lmrp_pkg::DATA_W-1:0]         s_word_data,
    input  logic [lmrp_pkg::BYTES_W-1:0]        s_word_bytes,
    input  logic                                s_end_of_message,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [lmrp_pkg::DATA_W-1:0]         m_out_word,
    output logic [lmrp_pkg::BYTES_W-1:0]        m_out_bytes,
    output logic                                m_out_last
);

    lmrp_pkg::mem_req_t          mem_req;
    logic [lmrp_pkg::DATA_W-1:0] mem_rdata;

    lmrp_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_side           (s_side),
        .s_word_data      (s_word_data),
        .s_word_bytes     (s_word_bytes),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_out_word       (m_out_word),
        .m_out_bytes      (m_out_bytes),
        .m_out_last       (m_out_last),
        .mem_req          (mem_req),
        .mem_rdata        (mem_rdata)
    );

    lmrp_store u_store (
        .aclk      (aclk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule
